### rtl/windowed_temperature_statistics_defines.svh
// Assertion macros for the windowed temperature statistics block.
// Included by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef WINDOWED_TEMPERATURE_STATISTICS_DEFINES_SVH
`define WINDOWED_TEMPERATURE_STATISTICS_DEFINES_SVH
`ifndef ASSERT_OFF
// Property checked on every clock edge outside reset.
`define WTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define WTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WTS_ASSERT(label, prop, msg)
`define WTS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### rtl/wts_pkg.sv
// Shared constants and types for the windowed temperature statistics block.
// No dependencies; used by every other RTL file but the assertion macro header.
package wts_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int WINDOW    = 3600;                 // ring depth, 2..4096
  localparam int IDX_W     = $clog2(WINDOW);
  localparam int CNT_W     = $clog2(WINDOW + 1);   // holds 0..WINDOW
  localparam int SUM_W     = 28;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  typedef logic signed [SAMPLE_W-1:0] temp_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [SUM_W-1:0] mag;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    temp_t quot;
  } div_rsp_t;

endpackage

### rtl/wts_sample_if.sv
// Input channel: one temperature sample per item, valid/ready handshake.
// Depends on wts_pkg.
interface wts_sample_if;
  logic          valid;
  logic          ready;
  wts_pkg::temp_t sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

### rtl/wts_result_if.sv
// Result channel: sample echo, window average, all-time max and min.
// Depends on wts_pkg.
interface wts_result_if;
  logic          valid;
  logic          ready;
  wts_pkg::temp_t current;
  wts_pkg::temp_t average;
  wts_pkg::temp_t maximum;
  wts_pkg::temp_t minimum;

  modport source (output valid, current, average, maximum, minimum, input ready);
  modport sink   (input valid, current, average, maximum, minimum, output ready);
endinterface

### rtl/wts_front.sv
// Front end: accepts samples and holds them in a two-entry queue for the back end.
// Depends on wts_pkg, wts_sample_if and the assertion macro header.
`include "windowed_temperature_statistics_defines.svh"

module wts_front (
  input  logic                clk,
  input  logic                rst_n,
  wts_sample_if.sink          in_ch,
  output logic                q_valid,
  output wts_pkg::temp_t      q_sample,
  input  logic                q_pop
);

  wts_pkg::temp_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push, pop;

  assign in_ch.ready = (count_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_pop && q_valid;
  assign q_valid     = (count_r != 2'd0);
  assign q_sample    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_ch.sample;
    end
  end

  `WTS_ASSERT(a_count_range, count_r != 2'd3, "queue count out of range")
  `WTS_ASSERT(a_ptr_count, (count_r == 2'd1) == (wr_ptr_r != rd_ptr_r),
              "queue pointers disagree with count")
  `WTS_ASSERT_NEXT(a_push_grows, push && !pop, count_r == $past(count_r) + 2'd1,
                   "push without pop did not grow the queue")

endmodule

### rtl/wts_div.sv
// Bit-serial restoring divider: signed window sum over a positive sample count.
// One quotient bit per cycle, SUM_W quotient bits per division. Depends on wts_pkg.
module wts_div (
  input  logic              clk,
  input  logic              rst_n,
  input  wts_pkg::div_req_t req,
  output wts_pkg::div_rsp_t rsp
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [wts_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [wts_pkg::SUM_W-1:0]         q_r, q_nxt;
  logic [wts_pkg::CNT_W-1:0]         rem_r, rem_nxt;
  logic [wts_pkg::CNT_W-1:0]         dvs_r, dvs_nxt;
  logic                              neg_r, neg_nxt;
  logic [wts_pkg::CNT_W:0]           rem_sh;
  logic [wts_pkg::CNT_W:0]           rem_sub;
  logic                              ge;
  logic [wts_pkg::SAMPLE_W-1:0]      q_low;

  always_comb begin
    rem_sh  = {rem_r, q_r[wts_pkg::SUM_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_sub = rem_sh - {1'b0, dvs_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = wts_pkg::DIV_CNT_W'(wts_pkg::SUM_W - 1);
      q_nxt    = req.mag;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      neg_nxt  = req.neg;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits back in CNT_W bits
      rem_nxt = ge ? rem_sub[wts_pkg::CNT_W-1:0] : rem_sh[wts_pkg::CNT_W-1:0];
      q_nxt   = {q_r[wts_pkg::SUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  // mean of 16-bit samples fits in 16 bits, so the low bits are the quotient
  assign q_low    = q_r[wts_pkg::SAMPLE_W-1:0];
  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? -q_low : q_low;

endmodule

### rtl/wts_back.sv
// Back end: ring store, running sum, fill count, all-time max/min and result register.
// Depends on wts_pkg, wts_div, wts_result_if and the assertion macro header.
`include "windowed_temperature_statistics_defines.svh"

module wts_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  wts_pkg::temp_t      q_sample,
  output logic                q_pop,
  wts_result_if.source        out_ch
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_DIV  = 4'b0100,
    S_WB   = 4'b1000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [wts_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [wts_pkg::CNT_W-1:0]      fill_r, fill_nxt;
  logic signed [wts_pkg::SUM_W-1:0] sum_r, sum_nxt;
  wts_pkg::temp_t                 max_r, max_nxt;
  wts_pkg::temp_t                 min_r, min_nxt;
  wts_pkg::temp_t                 cur_r;
  wts_pkg::temp_t                 old_r;
  logic                           out_vld_r, out_vld_nxt;
  wts_pkg::temp_t                 o_cur_r, o_avg_r, o_max_r, o_min_r;

  wts_pkg::temp_t                 ring [wts_pkg::WINDOW];

  logic                           full;
  wts_pkg::temp_t                 old_val;
  logic signed [wts_pkg::SUM_W-1:0] cur_ext, old_ext, sum_calc;
  logic [wts_pkg::SUM_W-1:0]      sum_neg;
  logic                           ring_we;
  logic                           load_out;
  wts_pkg::div_req_t              div_req;
  wts_pkg::div_rsp_t              div_rsp;

  assign full    = (fill_r == wts_pkg::CNT_W'(wts_pkg::WINDOW));
  assign old_val = full ? old_r : '0;
  assign cur_ext = {{(wts_pkg::SUM_W - wts_pkg::SAMPLE_W){cur_r[wts_pkg::SAMPLE_W-1]}}, cur_r};
  assign old_ext = {{(wts_pkg::SUM_W - wts_pkg::SAMPLE_W){old_val[wts_pkg::SAMPLE_W-1]}},
                    old_val};
  assign sum_calc = sum_r + cur_ext - old_ext;
  assign sum_neg  = -sum_calc;

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign ring_we  = (state_r == S_SUM);
  assign load_out = (state_r == S_WB) && (!out_vld_r || out_ch.ready);

  always_comb begin
    div_req.start   = (state_r == S_SUM);
    div_req.neg     = sum_calc[wts_pkg::SUM_W-1];
    div_req.mag     = sum_calc[wts_pkg::SUM_W-1] ? sum_neg : sum_calc;
    div_req.divisor = full ? wts_pkg::CNT_W'(wts_pkg::WINDOW) : fill_r + 1'b1;
  end

  wts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    fill_nxt    = fill_r;
    sum_nxt     = sum_r;
    max_nxt     = max_r;
    min_nxt     = min_r;
    out_vld_nxt = out_vld_r;

    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        sum_nxt = sum_calc;
        if (!full) begin
          fill_nxt = fill_r + 1'b1;
        end
        idx_nxt = (idx_r == wts_pkg::IDX_W'(wts_pkg::WINDOW - 1)) ? '0 : idx_r + 1'b1;
        if (cur_r > max_r) begin
          max_nxt = cur_r;
        end
        if (cur_r < min_r) begin
          min_nxt = cur_r;
        end
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (load_out) begin
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= '0;
      fill_r    <= '0;
      sum_r     <= '0;
      max_r     <= 16'sh8000;
      min_r     <= 16'sh7fff;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      fill_r    <= fill_nxt;
      sum_r     <= sum_nxt;
      max_r     <= max_nxt;
      min_r     <= min_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // ring store: the oldest slot is read as the item is popped, written in the sum step
  always_ff @(posedge clk) begin
    if (q_pop) begin
      old_r <= ring[idx_r];
    end
    if (ring_we) begin
      ring[idx_r] <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_sample;
    end
    if (load_out) begin
      o_cur_r <= cur_r;
      o_avg_r <= div_rsp.quot;
      o_max_r <= max_r;
      o_min_r <= min_r;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.current = o_cur_r;
  assign out_ch.average = o_avg_r;
  assign out_ch.maximum = o_max_r;
  assign out_ch.minimum = o_min_r;

  `WTS_ASSERT(a_fill_range,
              fill_r <= wts_pkg::CNT_W'(wts_pkg::WINDOW) &&
              idx_r <= wts_pkg::IDX_W'(wts_pkg::WINDOW - 1),
              "fill count or write index out of range")
  `WTS_ASSERT(a_idx_tracks_fill,
              (fill_r < wts_pkg::CNT_W'(wts_pkg::WINDOW)) |->
              (wts_pkg::CNT_W'(idx_r) == fill_r),
              "write index lost track of fill count while filling")
  `WTS_ASSERT(a_max_ge_min, (fill_r != '0) |-> (max_r >= min_r),
              "maximum fell below minimum after a sample")
  `WTS_ASSERT(a_done_in_div, div_rsp.done |-> (state_r == S_DIV),
              "divider finished outside the divide state")

endmodule

### rtl/windowed_temperature_statistics.sv
// Top level of the windowed temperature statistics block.
// Depends on wts_pkg, wts_sample_if, wts_result_if, wts_front and wts_back.

// Takes one signed temperature sample (1/16 degree C) per item and returns one result per
// item: the sample, the mean over the last WINDOW samples (over all samples while fewer
// have arrived, truncated toward zero), and the largest and smallest sample since reset.
// In the back end each item steps through reading the oldest ring entry, updating sum and
// count, the bit-serial divider (one quotient bit per cycle), handing the quotient over
// and loading the result register, which waits while an earlier result is held and not
// taken. A two-entry queue in front accepts samples while the back end works, and the
// result register lets the next item start while a result waits. The ring is a
// single-port-write, registered-read memory of WINDOW entries with no clearing pass; a read
// entry is used only once the ring is full, so every used value comes from a written slot.
module windowed_temperature_statistics (
  input  logic           clk,
  input  logic           rst_n,
  wts_sample_if.sink     in_ch,
  wts_result_if.source   out_ch
);

  logic           q_valid;
  wts_pkg::temp_t q_sample;
  logic           q_pop;

  wts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_valid  (q_valid),
    .q_sample (q_sample),
    .q_pop    (q_pop)
  );

  wts_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_sample (q_sample),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule
